/* design/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define GFDM_ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gfdm: clocked check failed");

// Clocked check that also runs during reset.
`define GFDM_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("gfdm: reset check failed");

`endif

/* design/gfdm_pkg.sv */
package gfdm_pkg;

  // Frame store and grid limits.
  localparam int MAX_WIDTH        = 512;
  localparam int MAX_HEIGHT       = 512;
  localparam int MAX_GRID_ROWS    = 8;
  localparam int MAX_GRID_COLUMNS = 8;

  localparam int X_W    = $clog2(MAX_WIDTH);
  localparam int Y_W    = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = X_W + Y_W;
  localparam int ROW_W  = (MAX_GRID_ROWS > 1) ? $clog2(MAX_GRID_ROWS) : 1;
  localparam int COL_W  = (MAX_GRID_COLUMNS > 1) ? $clog2(MAX_GRID_COLUMNS) : 1;
  localparam int CELLS  = MAX_GRID_ROWS * MAX_GRID_COLUMNS;

  // Field widths of the channels and registers.
  localparam int PIX_W  = 8;
  localparam int CELL_W = 6;
  localparam int DIM_W  = 10;
  localparam int GRID_W = 4;
  localparam int STEP_W = 10;
  localparam int THR_W  = 8;
  localparam int PCT_W  = 14;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 14;

  // Arithmetic widths.
  localparam int SUM_W       = 10;
  localparam int DIV3_MUL    = 683;
  localparam int DIV3_SHIFT  = 11;
  localparam int DIV3_PROD_W = SUM_W + 10;
  localparam int CNT_W       = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SMP_W       = DIM_W;
  localparam int PCT_FULL    = 10000;
  localparam int LHS_W       = CNT_W + PCT_W;
  localparam int AREA_W      = 2 * SMP_W;
  localparam int RHS_W       = AREA_W + PCT_W;

  // Register reset values.
  localparam int RST_FRAME_WIDTH     = 512;
  localparam int RST_FRAME_HEIGHT    = 512;
  localparam int RST_GRID_ROWS       = 8;
  localparam int RST_GRID_COLUMNS    = 8;
  localparam int RST_VERTICAL_STEP   = 1;
  localparam int RST_HORIZONTAL_STEP = 1;
  localparam int RST_PIXEL_THRESHOLD = 30;
  localparam int RST_MOTION_PERCENT  = 1000;

  typedef enum logic [CFG_AW-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_GRID_ROWS,
    REG_GRID_COLUMNS,
    REG_VERTICAL_STEP,
    REG_HORIZONTAL_STEP,
    REG_PIXEL_THRESHOLD,
    REG_MOTION_PERCENT
  } cfg_reg_t;

endpackage

/* design/gfdm_pix_if.sv */
interface gfdm_pix_if;
  logic                       valid;
  logic                       ready;
  logic [gfdm_pkg::PIX_W-1:0] red;
  logic [gfdm_pkg::PIX_W-1:0] green;
  logic [gfdm_pkg::PIX_W-1:0] blue;
  logic                       frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

/* design/gfdm_cell_if.sv */
interface gfdm_cell_if;
  logic                        valid;
  logic                        ready;
  logic [gfdm_pkg::CELL_W-1:0] cell_index;
  logic                        motion;
  logic                        last;

  modport source (output valid, cell_index, motion, last, input ready);
  modport sink   (input valid, cell_index, motion, last, output ready);
endinterface

/* design/grid_frame_difference_motion.sv */
// Channel   Dir  Payload                        Transfer
// in_pix    in   red, green, blue, frame_start  valid && ready
// out_cell  out  cell_index, motion, last       valid && ready
// cfg_*     in   cfg_addr, cfg_wdata            cfg_we
//
// One pixel a cycle while in_pix.ready is high: a pixel reads its reference
// gray level from the frame memory in the cycle it is taken and writes it
// back in the next one. At frame end each cell goes through S_RD, S_MUL,
// S_SCALE, S_DEC and S_OUT, waiting in S_OUT on out_cell.ready; no pixel is
// taken meanwhile. After reset and after each register write the span
// divider runs with in_pix.ready low. Reset is synchronous and active low.
module grid_frame_difference_motion (
  input  logic                          clk,
  input  logic                          rst_n,
  gfdm_pix_if.sink                      in_pix,
  gfdm_cell_if.source                   out_cell,
  input  logic                          cfg_we,
  input  logic [gfdm_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [gfdm_pkg::CFG_DW-1:0]   cfg_wdata
);
  import gfdm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_MUL, S_SCALE, S_DEC, S_OUT
  } state_t;

  localparam int DCNT_W = $clog2(DIM_W + 1);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) res = DIM_W'(1);
    else if (v > hi) res = hi;
    return res;
  endfunction

  function automatic logic [GRID_W-1:0] clamp_grid(input logic [GRID_W-1:0] v,
                                                   input logic [GRID_W-1:0] hi);
    logic [GRID_W-1:0] res;
    res = v;
    if (v == '0) res = GRID_W'(1);
    else if (v > hi) res = hi;
    return res;
  endfunction

  // Configuration registers, held in their clamped form.
  logic [DIM_W-1:0]  w_r, h_r;
  logic [GRID_W-1:0] rows_r, cols_r;
  logic [STEP_W-1:0] vstep_r, hstep_r;
  logic [THR_W-1:0]  thr_r;
  logic [PCT_W-1:0]  pct_r;

  // Cell span divider.
  logic              div_busy_r;
  logic [DCNT_W-1:0] div_cnt_r;
  logic [DIM_W-1:0]  qx_r, qy_r;
  logic [GRID_W-1:0] rx_r, ry_r;
  logic [GRID_W-1:0] tx, ty;

  // Raster position of the next pixel.
  logic [X_W-1:0]    x_r, xin_r;
  logic [Y_W-1:0]    y_r, yin_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [STEP_W-1:0] hph_r, vph_r;
  logic [X_W-1:0]    x_nxt, xin_nxt;
  logic [Y_W-1:0]    y_nxt, yin_nxt;
  logic [COL_W-1:0]  col_nxt;
  logic [ROW_W-1:0]  row_nxt;
  logic [STEP_W-1:0] hph_nxt, vph_nxt;
  logic              frame_last;

  // Current pixel as seen at the input.
  logic                    in_xfer, fs;
  logic [X_W-1:0]          cx, cxin;
  logic [Y_W-1:0]          cy, cyin;
  logic [COL_W-1:0]        ccol, col0;
  logic [ROW_W-1:0]        crow, row0;
  logic [STEP_W-1:0]       chph, cvph;
  logic                    x_first, y_first, x_line_end, y_frame_end;
  logic                    col_adv, row_adv;
  logic [GRID_W-1:0]       cols_m1, rows_m1;
  logic [ROW_W+GRID_W-1:0] idx_full;
  logic [CELL_W-1:0]       cur_idx;
  logic [SUM_W-1:0]        sum;
  logic [DIV3_PROD_W-1:0]  div3_prod;
  logic [PIX_W-1:0]        gray;

  // Per-column and per-row sample counts.
  logic [SMP_W-1:0] sw_r   [MAX_GRID_COLUMNS];
  logic [SMP_W-1:0] sh_r   [MAX_GRID_ROWS];
  logic [SMP_W-1:0] sw_nxt [MAX_GRID_COLUMNS];
  logic [SMP_W-1:0] sh_nxt [MAX_GRID_ROWS];

  // Memories.
  logic [PIX_W-1:0] ref_mem [2**ADDR_W];
  logic [CNT_W-1:0] cnt_mem [CELLS];
  logic [PIX_W-1:0] ref_rd_r;
  logic [CNT_W-1:0] cnt_rd_r;
  logic             cnt_rdv_r;
  logic [CELLS-1:0] cnt_vld_r;
  logic [CELL_W-1:0] rd_idx;
  logic             vld_clr;

  // Write-back stage.
  logic              p_valid_r, p_samp_r, p_fs_r, p_last_r;
  logic [PIX_W-1:0]  p_gray_r;
  logic [ADDR_W-1:0] p_addr_r;
  logic [CELL_W-1:0] p_idx_r;
  logic              wr_v_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [PIX_W-1:0]  wr_gray_r;
  logic [CELL_W-1:0] wr_idx_r;
  logic [CNT_W-1:0]  wr_cnt_r;
  logic [PIX_W-1:0]  prev, diff;
  logic              hit;
  logic [CNT_W-1:0]  cnt_old, cnt_new;

  // Report sequencer.
  state_t            state_r;
  logic              have_ref_r;
  logic [CELL_W-1:0] rep_idx_r;
  logic [ROW_W-1:0]  rep_row_r;
  logic [COL_W-1:0]  rep_col_r;
  logic              rep_last, fin;
  logic [CNT_W-1:0]  cnt_eff;
  logic [LHS_W-1:0]  lhs_r;
  logic [AREA_W-1:0] area_r;
  logic [RHS_W-1:0]  rhs_r;
  logic              nz_r;
  logic              out_valid_r, out_motion_r, out_last_r;
  logic [CELL_W-1:0] out_idx_r;

  // Handshake.
  assign in_xfer      = in_pix.valid && in_pix.ready;
  assign in_pix.ready = (state_r == S_IDLE) && !div_busy_r && !(p_valid_r && p_last_r);
  assign out_cell.valid      = out_valid_r;
  assign out_cell.cell_index = out_idx_r;
  assign out_cell.motion     = out_motion_r;
  assign out_cell.last       = out_last_r;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r     <= DIM_W'(RST_FRAME_WIDTH);
      h_r     <= DIM_W'(RST_FRAME_HEIGHT);
      rows_r  <= GRID_W'(RST_GRID_ROWS);
      cols_r  <= GRID_W'(RST_GRID_COLUMNS);
      vstep_r <= STEP_W'(RST_VERTICAL_STEP);
      hstep_r <= STEP_W'(RST_HORIZONTAL_STEP);
      thr_r   <= THR_W'(RST_PIXEL_THRESHOLD);
      pct_r   <= PCT_W'(RST_MOTION_PERCENT);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_FRAME_WIDTH:
          w_r <= clamp_dim(cfg_wdata[DIM_W-1:0], DIM_W'(MAX_WIDTH));
        REG_FRAME_HEIGHT:
          h_r <= clamp_dim(cfg_wdata[DIM_W-1:0], DIM_W'(MAX_HEIGHT));
        REG_GRID_ROWS:
          rows_r <= clamp_grid(cfg_wdata[GRID_W-1:0], GRID_W'(MAX_GRID_ROWS));
        REG_GRID_COLUMNS:
          cols_r <= clamp_grid(cfg_wdata[GRID_W-1:0], GRID_W'(MAX_GRID_COLUMNS));
        REG_VERTICAL_STEP:
          vstep_r <= (cfg_wdata[STEP_W-1:0] == '0) ? STEP_W'(1) : cfg_wdata[STEP_W-1:0];
        REG_HORIZONTAL_STEP:
          hstep_r <= (cfg_wdata[STEP_W-1:0] == '0) ? STEP_W'(1) : cfg_wdata[STEP_W-1:0];
        REG_PIXEL_THRESHOLD:
          thr_r <= cfg_wdata[THR_W-1:0];
        REG_MOTION_PERCENT:
          pct_r <= (cfg_wdata > CFG_DW'(PCT_FULL)) ? PCT_W'(PCT_FULL) : cfg_wdata[PCT_W-1:0];
      endcase
    end
  end

  // Restoring divider for the cell spans, one quotient bit per cycle.
  assign tx = {rx_r[GRID_W-2:0], qx_r[DIM_W-1]};
  assign ty = {ry_r[GRID_W-2:0], qy_r[DIM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= '0;
    end else if (div_busy_r) begin
      if (div_cnt_r == '0) begin
        qx_r <= w_r;
        qy_r <= h_r;
        rx_r <= '0;
        ry_r <= '0;
      end else begin
        if (tx >= cols_r) begin
          rx_r <= tx - cols_r;
          qx_r <= {qx_r[DIM_W-2:0], 1'b1};
        end else begin
          rx_r <= tx;
          qx_r <= {qx_r[DIM_W-2:0], 1'b0};
        end
        if (ty >= rows_r) begin
          ry_r <= ty - rows_r;
          qy_r <= {qy_r[DIM_W-2:0], 1'b1};
        end else begin
          ry_r <= ty;
          qy_r <= {qy_r[DIM_W-2:0], 1'b0};
        end
        if (div_cnt_r == DCNT_W'(DIM_W)) div_busy_r <= 1'b0;
      end
      div_cnt_r <= div_cnt_r + DCNT_W'(1);
    end
  end

  // Position of the current pixel; the first pixel of a line or frame sits
  // at the first cell, or at the last one when the span is zero.
  assign fs      = in_pix.frame_start;
  assign cx      = fs ? '0 : x_r;
  assign cy      = fs ? '0 : y_r;
  assign x_first = (cx == '0);
  assign y_first = (cy == '0);
  assign cols_m1 = cols_r - GRID_W'(1);
  assign rows_m1 = rows_r - GRID_W'(1);
  assign col0    = (qx_r == '0) ? cols_m1[COL_W-1:0] : '0;
  assign row0    = (qy_r == '0) ? rows_m1[ROW_W-1:0] : '0;
  assign ccol    = x_first ? col0 : col_r;
  assign cxin    = x_first ? '0 : xin_r;
  assign chph    = x_first ? '0 : hph_r;
  assign crow    = y_first ? row0 : row_r;
  assign cyin    = y_first ? '0 : yin_r;
  assign cvph    = y_first ? '0 : vph_r;

  assign x_line_end  = (DIM_W'(cx) + DIM_W'(1)) >= w_r;
  assign y_frame_end = (DIM_W'(cy) + DIM_W'(1)) >= h_r;
  assign col_adv = (qx_r != '0) && (GRID_W'(ccol) < cols_m1) &&
                   ((DIM_W'(cxin) + DIM_W'(1)) == qx_r);
  assign row_adv = (qy_r != '0) && (GRID_W'(crow) < rows_m1) &&
                   ((DIM_W'(cyin) + DIM_W'(1)) == qy_r);

  assign idx_full = (ROW_W+GRID_W)'(crow) * (ROW_W+GRID_W)'(cols_r) +
                    (ROW_W+GRID_W)'(ccol);
  assign cur_idx  = idx_full[CELL_W-1:0];

  // Gray level: channel sum times a reciprocal of three.
  assign sum       = SUM_W'(in_pix.red) + SUM_W'(in_pix.green) + SUM_W'(in_pix.blue);
  assign div3_prod = DIV3_PROD_W'(sum) * DIV3_PROD_W'(DIV3_MUL);
  assign gray      = div3_prod[DIV3_SHIFT +: PIX_W];

  // Raster advance.
  always_comb begin
    x_nxt      = '0;
    col_nxt    = ccol;
    xin_nxt    = '0;
    hph_nxt    = '0;
    y_nxt      = cy;
    row_nxt    = crow;
    yin_nxt    = cyin;
    vph_nxt    = cvph;
    frame_last = 1'b0;
    if (!x_line_end) begin
      x_nxt = cx + X_W'(1);
      if (col_adv) begin
        col_nxt = ccol + COL_W'(1);
      end else begin
        xin_nxt = cxin + X_W'(1);
        hph_nxt = ((chph + STEP_W'(1)) == hstep_r) ? '0 : chph + STEP_W'(1);
      end
    end else if (!y_frame_end) begin
      y_nxt = cy + Y_W'(1);
      if (row_adv) begin
        row_nxt = crow + ROW_W'(1);
        yin_nxt = '0;
        vph_nxt = '0;
      end else begin
        yin_nxt = cyin + Y_W'(1);
        vph_nxt = ((cvph + STEP_W'(1)) == vstep_r) ? '0 : cvph + STEP_W'(1);
      end
    end else begin
      y_nxt      = '0;
      yin_nxt    = '0;
      vph_nxt    = '0;
      frame_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      x_r <= '0;
      y_r <= '0;
    end else if (in_xfer) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      col_r <= col_nxt;
      xin_r <= xin_nxt;
      hph_r <= hph_nxt;
      row_r <= row_nxt;
      yin_r <= yin_nxt;
      vph_r <= vph_nxt;
    end
  end

  // Sample counts: columns on the first line, rows on the first pixel of
  // each line, both restarted at the top left pixel.
  always_comb begin
    for (int k = 0; k < MAX_GRID_COLUMNS; k++) begin
      sw_nxt[k] = ((x_first && y_first) ? '0 : sw_r[k]) +
                  SMP_W'(y_first && (chph == '0) && (ccol == COL_W'(k)));
    end
    for (int k = 0; k < MAX_GRID_ROWS; k++) begin
      sh_nxt[k] = ((x_first && y_first) ? '0 : sh_r[k]) +
                  SMP_W'(x_first && (cvph == '0) && (crow == ROW_W'(k)));
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sw_r <= sw_nxt;
      sh_r <= sh_nxt;
    end
  end

  // Reference frame memory: read on transfer, written back in the following cycle.
  always_ff @(posedge clk) begin
    if (in_xfer) ref_rd_r <= ref_mem[{cy, cx}];
    if (p_valid_r) ref_mem[p_addr_r] <= p_gray_r;
  end

  // Change count memory, shared by the pixel path and the report.
  assign rd_idx  = (state_r == S_IDLE) ? cur_idx : rep_idx_r;
  assign vld_clr = (in_xfer && fs) || cfg_we || fin;

  always_ff @(posedge clk) begin
    if (in_xfer || state_r == S_RD) begin
      cnt_rd_r  <= cnt_mem[rd_idx];
      cnt_rdv_r <= cnt_vld_r[rd_idx] && !(in_xfer && fs);
    end
    if (p_valid_r) cnt_mem[p_idx_r] <= cnt_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || vld_clr) begin
      cnt_vld_r <= '0;
    end else if (p_valid_r) begin
      cnt_vld_r[p_idx_r] <= 1'b1;
    end
  end

  // Write-back stage with forwarding from the previous pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      wr_v_r    <= 1'b0;
    end else begin
      p_valid_r <= in_xfer;
      wr_v_r    <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      p_gray_r <= gray;
      p_addr_r <= {cy, cx};
      p_idx_r  <= cur_idx;
      p_samp_r <= have_ref_r && (chph == '0) && (cvph == '0);
      p_fs_r   <= fs;
      p_last_r <= frame_last;
    end
    wr_addr_r <= p_addr_r;
    wr_gray_r <= p_gray_r;
    wr_idx_r  <= p_idx_r;
    wr_cnt_r  <= cnt_new;
  end

  assign prev = (wr_v_r && (wr_addr_r == p_addr_r)) ? wr_gray_r : ref_rd_r;
  assign diff = (p_gray_r >= prev) ? p_gray_r - prev : prev - p_gray_r;
  assign hit  = p_samp_r && (diff >= thr_r);

  always_comb begin
    if (wr_v_r && (wr_idx_r == p_idx_r) && !p_fs_r) cnt_old = wr_cnt_r;
    else if (cnt_rdv_r) cnt_old = cnt_rd_r;
    else cnt_old = '0;
    cnt_new = cnt_old + CNT_W'(hit);
  end

  // Report over the cells at frame end.
  assign rep_last = (GRID_W'(rep_row_r) == rows_m1) && (GRID_W'(rep_col_r) == cols_m1);
  assign fin      = (state_r == S_OUT) && out_cell.ready && rep_last;
  assign cnt_eff  = cnt_rdv_r ? cnt_rd_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      have_ref_r <= 1'b0;
    end else if (fin) begin
      have_ref_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (p_valid_r && p_last_r) begin
            rep_idx_r <= '0;
            rep_row_r <= '0;
            rep_col_r <= '0;
            state_r   <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          lhs_r   <= LHS_W'(cnt_eff) * LHS_W'(PCT_FULL);
          nz_r    <= (cnt_eff != '0);
          area_r  <= AREA_W'(sw_r[rep_col_r]) * AREA_W'(sh_r[rep_row_r]);
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          rhs_r   <= RHS_W'(area_r) * RHS_W'(pct_r);
          state_r <= S_DEC;
        end
        S_DEC: begin
          out_valid_r  <= 1'b1;
          out_idx_r    <= rep_idx_r;
          out_last_r   <= rep_last;
          out_motion_r <= have_ref_r && nz_r && (RHS_W'(lhs_r) >= rhs_r);
          state_r      <= S_OUT;
        end
        S_OUT: begin
          if (out_cell.ready) begin
            out_valid_r <= 1'b0;
            if (rep_last) begin
              state_r <= S_IDLE;
            end else begin
              rep_idx_r <= rep_idx_r + CELL_W'(1);
              if (GRID_W'(rep_col_r) == cols_m1) begin
                rep_col_r <= '0;
                rep_row_r <= rep_row_r + ROW_W'(1);
              end else begin
                rep_col_r <= rep_col_r + COL_W'(1);
              end
              state_r <= S_RD;
            end
          end
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* design/gfdm_checker.sv */
`include "assert_macros.svh"

module gfdm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gfdm_pkg::CELL_W-1:0] out_cell_index,
  input logic                        out_motion,
  input logic                        out_last
);
  import gfdm_pkg::*;

  // No result is shown in the cycle after reset.
  `GFDM_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_valid)

  // A stalled result holds its payload.
  `GFDM_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_cell_index) && $stable(out_motion) && $stable(out_last))

  // Pixels are not taken while a cell result is shown.
  `GFDM_ASSERT_CLK(a_no_pix_in_report, out_valid |-> !in_ready)

  // A report that is not finished keeps the pixel input closed.
  `GFDM_ASSERT_CLK(a_report_blocks, out_valid && out_ready && !out_last |=> !in_ready)

  // The valid input is observed so that stalls on the pixel side are seen.
  `GFDM_ASSERT_CLK(a_in_blocked, in_valid && out_valid |-> !in_ready)

endmodule

bind grid_frame_difference_motion gfdm_checker u_gfdm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_pix.valid),
  .in_ready       (in_pix.ready),
  .out_valid      (out_cell.valid),
  .out_ready      (out_cell.ready),
  .out_cell_index (out_cell.cell_index),
  .out_motion     (out_cell.motion),
  .out_last       (out_cell.last)
);

/* tb/sv/grid_frame_difference_motion_test.sv */
module grid_frame_difference_motion_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gfdm_pkg::*;

  typedef struct {
    logic [CELL_W-1:0] cell_index;
    logic              motion;
    logic              last;
  } cell_result_t;

  // Predicts the per-cell motion report and checks the block's results against it.
  class motion_scoreboard;
    int unsigned  frame_w, frame_h, rows, cols, v_step, h_step, threshold, percent;
    bit           have_ref;
    byte unsigned ref_gray [MAX_WIDTH*MAX_HEIGHT];
    int unsigned  changed [CELLS];
    int unsigned  pos_x, pos_y;
    cell_result_t pending [$];
    int           errors, mismatches, checked, reports;

    function new();
      frame_w = RST_FRAME_WIDTH;      frame_h = RST_FRAME_HEIGHT;
      rows = RST_GRID_ROWS;           cols = RST_GRID_COLUMNS;
      v_step = RST_VERTICAL_STEP;     h_step = RST_HORIZONTAL_STEP;
      threshold = RST_PIXEL_THRESHOLD; percent = RST_MOTION_PERCENT;
      restart();
    endfunction

    function void restart();
      have_ref = 0;
      foreach (changed[i]) changed[i] = 0;
      pos_x = 0;
      pos_y = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void write_reg(cfg_reg_t r, int unsigned v);
      case (r)
        REG_FRAME_WIDTH:     frame_w = clamp(v & 10'h3ff, 1, MAX_WIDTH);
        REG_FRAME_HEIGHT:    frame_h = clamp(v & 10'h3ff, 1, MAX_HEIGHT);
        REG_GRID_ROWS:       rows = clamp(v & 4'hf, 1, MAX_GRID_ROWS);
        REG_GRID_COLUMNS:    cols = clamp(v & 4'hf, 1, MAX_GRID_COLUMNS);
        REG_VERTICAL_STEP:   v_step = clamp(v & 10'h3ff, 1, 1023);
        REG_HORIZONTAL_STEP: h_step = clamp(v & 10'h3ff, 1, 1023);
        REG_PIXEL_THRESHOLD: threshold = v & 8'hff;
        REG_MOTION_PERCENT:  percent = clamp(v & 14'h3fff, 0, PCT_FULL);
        default: ;
      endcase
      restart();
    endfunction

    // Cell along one axis for a position; the offset inside the cell is returned too.
    function void place(int unsigned p, int unsigned size, int unsigned n,
                        output int unsigned cell_no, output int unsigned offset);
      int unsigned span;
      span = size / n;
      cell_no = (span == 0) ? n - 1 : p / span;
      if (cell_no > n - 1) cell_no = n - 1;
      offset = p - cell_no * span;
    endfunction

    function int unsigned cell_size(int unsigned c, int unsigned size, int unsigned n);
      return (c == n - 1) ? size - c * (size / n) : size / n;
    endfunction

    // Takes one accepted pixel; on the last pixel of a frame queues the cell report.
    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
      int unsigned  gray, cx, cy, ox, oy, addr, prev, diff, w, h, idx;
      longint       sw, sh;
      cell_result_t res;
      gray = (int'(r) + int'(g) + int'(b)) / 3;
      if (fs) begin
        foreach (changed[i]) changed[i] = 0;
        pos_x = 0;
        pos_y = 0;
      end
      place(pos_x, frame_w, cols, cx, ox);
      place(pos_y, frame_h, rows, cy, oy);
      addr = pos_y * MAX_WIDTH + pos_x;
      prev = ref_gray[addr];
      if (have_ref && (ox % h_step == 0) && (oy % v_step == 0)) begin
        diff = (gray >= prev) ? gray - prev : prev - gray;
        if (diff >= threshold) changed[cy * cols + cx]++;
      end
      ref_gray[addr] = 8'(gray);
      if (pos_x + 1 < frame_w) begin
        pos_x++;
        return;
      end
      pos_x = 0;
      if (pos_y + 1 < frame_h) begin
        pos_y++;
        return;
      end
      pos_y = 0;
      for (int unsigned cr = 0; cr < rows; cr++) begin
        h = cell_size(cr, frame_h, rows);
        sh = (h + v_step - 1) / v_step;
        for (int unsigned cc = 0; cc < cols; cc++) begin
          w = cell_size(cc, frame_w, cols);
          sw = (w + h_step - 1) / h_step;
          idx = cr * cols + cc;
          res.cell_index = CELL_W'(idx);
          res.motion = have_ref && changed[idx] > 0 &&
                       longint'(changed[idx]) * PCT_FULL >= sw * sh * percent;
          res.last = (idx + 1 == rows * cols);
          pending.push_back(res);
        end
      end
      foreach (changed[i]) changed[i] = 0;
      have_ref = 1;
      reports++;
    endfunction

    function void check_cell(cell_result_t got);
      cell_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (mismatches++ < 10)
          $display("unexpected result: cell %0d motion %0d last %0d",
                   got.cell_index, got.motion, got.last);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.cell_index !== want.cell_index || got.motion !== want.motion ||
          got.last !== want.last) begin
        errors++;
        if (mismatches++ < 10)
          $display("mismatch: expected cell %0d motion %0d last %0d, got %0d %0d %0d",
                   want.cell_index, want.motion, want.last,
                   got.cell_index, got.motion, got.last);
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              cfg_we = 0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  bit                quiet = 0;
  int                sent = 0;
  int                cfg_writes = 0;
  logic [23:0]       last_pix [MAX_WIDTH*MAX_HEIGHT];

  gfdm_pix_if  pix ();
  gfdm_cell_if res_ch ();

  motion_scoreboard motion_sb = new();

  grid_frame_difference_motion uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (pix.sink),
    .out_cell (res_ch.source),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Check every result transfer.
  always @(posedge clk) begin
    cell_result_t got;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got.cell_index = res_ch.cell_index;
      got.motion = res_ch.motion;
      got.last = res_ch.last;
      motion_sb.check_cell(got);
    end
  end

  // The receiver stalls in random bursts until the quiet part of the run.
  initial begin
    res_ch.ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      res_ch.ready <= 1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        res_ch.ready <= 0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  // Sends one pixel, with an optional idle burst before it.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      pix.valid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    pix.valid <= 1;
    pix.red <= r;
    pix.green <= g;
    pix.blue <= b;
    pix.frame_start <= fs;
    do @(posedge clk); while (!pix.ready);
    motion_sb.note_pixel(r, g, b, fs);
    sent++;
  endtask

  // Sends one frame; chg is the percentage of pixels given new random colors.
  task automatic send_frame(int chg, int cut_at = -1);
    int unsigned n, addr;
    logic [23:0] c;
    n = motion_sb.frame_w * motion_sb.frame_h;
    for (int unsigned i = 0; i < n; i++) begin
      if (cut_at >= 0 && i == cut_at) return;
      addr = (i / motion_sb.frame_w) * MAX_WIDTH + (i % motion_sb.frame_w);
      c = ($urandom_range(0, 99) < chg) ? 24'($urandom) : last_pix[addr];
      case ($urandom_range(0, 40))
        0: c = 24'h000000;
        1: c = 24'hffffff;
        default: ;
      endcase
      last_pix[addr] = c;
      send_pixel(c[23:16], c[15:8], c[7:0], (i == 0) ? ($urandom_range(0, 9) != 0) : 1'b0);
    end
  endtask

  // Waits until every expected result has come and the block has settled.
  task automatic drain();
    pix.valid <= 0;
    @(posedge clk);
    while (motion_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, int unsigned v);
    cfg_we <= 1;
    cfg_addr <= r;
    cfg_wdata <= CFG_DW'(v);
    @(posedge clk);
    cfg_we <= 0;
    motion_sb.write_reg(r, v);
    cfg_writes++;
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned rows,
                           int unsigned cols, int unsigned vs, int unsigned hs,
                           int unsigned thr, int unsigned pct);
    drain();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_GRID_ROWS, rows);
    write_reg(REG_GRID_COLUMNS, cols);
    write_reg(REG_VERTICAL_STEP, vs);
    write_reg(REG_HORIZONTAL_STEP, hs);
    write_reg(REG_PIXEL_THRESHOLD, thr);
    write_reg(REG_MOTION_PERCENT, pct);
  endtask

  initial begin
    int rand_start;
    pix.valid = 0;
    pix.red = '0;
    pix.green = '0;
    pix.blue = '0;
    pix.frame_start = 0;
    foreach (last_pix[i]) last_pix[i] = 24'($urandom);
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Small frame, first frame reports zeros, then changed frames.
    configure(4, 3, 2, 2, 1, 1, 30, 1000);
    send_frame(100);
    send_frame(50);
    send_frame(0);
    // Zero width and steps act as one, oversized grid and share clamp; more cells than pixels.
    configure(0, 9, 15, 15, 0, 0, 255, 16383);
    send_frame(100);
    send_frame(100);
    // One line, one cell, steps beyond the cell, zero threshold and share.
    configure(16, 1, 1, 1, 512, 512, 0, 0);
    send_frame(100);
    send_frame(30);
    // Frames cut short; a new frame start, when sent, drops them with no report.
    configure(5, 4, 3, 2, 2, 3, 10, 5000);
    send_frame(100);
    send_frame(100, 7);
    send_frame(60);
    send_frame(60, 3);
    send_frame(60);
    drain();

    // Random geometry and content; before each new configuration the sender holds off until all results are in.
    rand_start = sent;
    while (sent - rand_start < 220) begin
      if (sent - rand_start > 170) quiet = 1;
      configure($urandom_range(0, 12), $urandom_range(0, 8), $urandom_range(0, 9),
                $urandom_range(0, 9), $urandom_range(0, 3), $urandom_range(0, 3),
                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 60),
                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16383)
                                            : $urandom_range(0, 10000));
      repeat ($urandom_range(2, 4)) begin
        if ($urandom_range(0, 5) == 0)
          send_frame($urandom_range(0, 100),
                     $urandom_range(0, motion_sb.frame_w * motion_sb.frame_h - 1));
        else
          send_frame($urandom_range(0, 100));
      end
    end
    drain();
    repeat (50) @(posedge clk);

    $display("Sent %0d pixels over %0d register writes; %0d frame reports, %0d cell results.",
             sent, cfg_writes, motion_sb.reports, motion_sb.checked);
    if (motion_sb.errors == 0 && motion_sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d errors, %0d results still expected", motion_sb.errors,
               motion_sb.pending.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5ms;
    $display("Timeout with %0d results still expected", motion_sb.pending.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
